[hw/rtl/hsg_pkg.sv]
// hsg_pkg: shared constants and types of the hop set generator.
// Used by the interfaces, the channel check unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hsg_pkg;

  localparam int HOP_COUNT_DEF = 16;
  localparam int NUM_BANDS_DEF = 4;

  localparam int SEED_W  = 32;
  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 4;
  localparam int LIMIT_W = 20;
  localparam int CNT_W   = 3;
  localparam int PROD_W  = 64;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd100000;

  localparam logic [SEED_W-1:0] GEN_MUL = 32'h0019660d;
  localparam logic [SEED_W-1:0] GEN_ADD = 32'h3c6ef35f;

  localparam int BAND_WIDTH = 42;
  localparam logic [CNT_W-1:0] BAND_CAP = 3'd5;

  // x mod 168 is done as ((x >> 3) mod 21) * 8 + (x & 7); the mod 21 uses
  // a floor reciprocal, which leaves the quotient at most one short.
  localparam int MOD_FACTOR  = 21;
  localparam int RECIP_SHIFT = 34;
  localparam logic [SEED_W-1:0] RECIP21 =
    32'((64'd1 << RECIP_SHIFT) / 64'(MOD_FACTOR));

  typedef struct packed {
    logic              clear;
    logic              commit;
    logic              parity;
    logic [CHAN_W-1:0] r168;
  } hsg_chk_ctrl_t;

  typedef struct packed {
    logic              ok;
    logic [CHAN_W-1:0] cand;
  } hsg_chk_stat_t;

endpackage

`default_nettype wire

[hw/rtl/hsg_if.sv]
// hsg_if: valid/ready channels for seed requests and hop results.
// Depends on hsg_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hsg_seed_if;
  logic                      valid;
  logic                      ready;
  logic [hsg_pkg::SEED_W-1:0] seed;

  modport source(output valid, output seed, input ready);
  modport sink(input valid, input seed, output ready);
endinterface

interface hsg_hop_if;
  logic                       valid;
  logic                       ready;
  logic [hsg_pkg::CHAN_W-1:0]  hop_channel;
  logic [hsg_pkg::INDEX_W-1:0] hop_index;
  logic                       last;
  logic                       failed;

  modport source(output valid, output hop_channel, output hop_index, output last,
                 output failed, input ready);
  modport sink(input valid, input hop_channel, input hop_index, input last,
               input failed, output ready);
endinterface

`default_nettype wire

[hw/rtl/hsg_mul.sv]
// hsg_mul: shared 32x32 multiplier with registered product.
// Serves both the generator step and the reciprocal reduction; uses hsg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsg_mul (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [hsg_pkg::SEED_W-1:0] a,
  input  wire logic [hsg_pkg::SEED_W-1:0] b,
  output logic      [hsg_pkg::PROD_W-1:0] p_r
);
  import hsg_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hsg_chk.sv]
// hsg_chk: hop store, per-band counts and the candidate accept test.
// Depends on hsg_pkg for the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hsg_chk #(
  parameter int HOP_COUNT = hsg_pkg::HOP_COUNT_DEF,
  parameter int NUM_BANDS = hsg_pkg::NUM_BANDS_DEF,
  parameter int FW = $clog2(HOP_COUNT + 1),
  parameter int IW = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire hsg_pkg::hsg_chk_ctrl_t ctrl,
  input  wire logic [FW-1:0]          fill,
  input  wire logic [IW-1:0]          rd_idx,
  output logic [hsg_pkg::CHAN_W-1:0]  rd_chan,
  output hsg_pkg::hsg_chk_stat_t      stat
);
  import hsg_pkg::*;

  localparam int BW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  logic [CHAN_W-1:0] store_r [HOP_COUNT];
  logic [CNT_W-1:0]  cnt_r   [NUM_BANDS];
  logic [CHAN_W-1:0] cand;
  logic [1:0]        raw;
  logic [BW-1:0]     band;
  logic              dup;

  always_comb begin
    cand = ctrl.r168 + 8'd1;
    if (ctrl.r168 >= 8'(3 * BAND_WIDTH)) begin
      raw = 2'd3;
    end else if (ctrl.r168 >= 8'(2 * BAND_WIDTH)) begin
      raw = 2'd2;
    end else if (ctrl.r168 >= 8'(BAND_WIDTH)) begin
      raw = 2'd1;
    end else begin
      raw = 2'd0;
    end
    if (int'(raw) > NUM_BANDS - 1) begin
      band = BW'(NUM_BANDS - 1);
    end else begin
      band = BW'(raw);
    end
    dup = 1'b0;
    for (int i = 0; i < HOP_COUNT; i++) begin
      if ((FW'(i) < fill) && (store_r[i] == cand)) begin
        dup = 1'b1;
      end
    end
    stat.cand = cand;
    stat.ok   = (cand[0] != ctrl.parity) && !dup && (cnt_r[band] < BAND_CAP);
  end

  assign rd_chan = store_r[rd_idx];

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      store_r[fill[IW-1:0]] <= cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      for (int j = 0; j < NUM_BANDS; j++) begin
        cnt_r[j] <= '0;
      end
    end else if (ctrl.commit) begin
      cnt_r[band] <= cnt_r[band] + 3'd1;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/hop_set_generator.sv]
// hop_set_generator: builds a hop channel set from a seed request.
//
// Channels: in_ch (seed requests) and out_ch (hop results), both valid/ready;
// a transfer happens on a rising edge with valid and ready high. cfg_wr_en
// with cfg_wr_data writes the attempt limit (reset 100000); write it only
// while the block is idle.
// One request at a time: in_ch.ready is high only while idle. Each draw
// steps through states DRAW, LCG, SHIFT, MULR, RED and CHECK, all sequenced
// around the one shared multiplier (generator step, then reciprocal mod-168
// reduction); a seed makes all its draws before the first result, and
// failure follows once limit draws have been made.
// Results: HOP_COUNT results, one per cycle while out_ch.ready is high,
// last set on the final one; or one result with failed and last set.
// A stalled receiver simply holds the current result; nothing is dropped.
// Reset (rst_n low, synchronous) returns to idle and restores the limit.
// Depends on hsg_pkg, hsg_if, hsg_mul and hsg_chk.
`timescale 1ns / 1ps
`default_nettype none

module hop_set_generator #(
  parameter int HOP_COUNT = hsg_pkg::HOP_COUNT_DEF,
  parameter int NUM_BANDS = hsg_pkg::NUM_BANDS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [hsg_pkg::LIMIT_W-1:0] cfg_wr_data,
  hsg_seed_if.sink                         in_ch,
  hsg_hop_if.source                        out_ch
);
  import hsg_pkg::*;

  localparam int FW = $clog2(HOP_COUNT + 1);
  localparam int IW = (HOP_COUNT > 1) ? $clog2(HOP_COUNT) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DRAW  = 4'd1;
  localparam logic [3:0] S_LCG   = 4'd2;
  localparam logic [3:0] S_SHIFT = 4'd3;
  localparam logic [3:0] S_MULR  = 4'd4;
  localparam logic [3:0] S_RED   = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;
  localparam logic [3:0] S_FAIL  = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] attempt_r, attempt_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [IW-1:0]     out_idx_r, out_idx_nxt;
  logic [SEED_W-1:0] lcg_r, lcg_nxt;
  logic [SEED_W-1:0] x_r, x_nxt;
  logic [CHAN_W-1:0] r168_r, r168_nxt;
  logic              parity_r, parity_nxt;

  logic              mul_en;
  logic [SEED_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;

  hsg_chk_ctrl_t     chk_ctrl;
  hsg_chk_stat_t     chk_stat;
  logic [CHAN_W-1:0] rd_chan;

  logic [5:0]        q6, qm6, r21a, r21;
  logic [SEED_W-1:0] idx_ext;

  hsg_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  hsg_chk #(
    .HOP_COUNT (HOP_COUNT),
    .NUM_BANDS (NUM_BANDS),
    .FW        (FW),
    .IW        (IW)
  ) u_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (chk_ctrl),
    .fill    (fill_r),
    .rd_idx  (out_idx_r),
    .rd_chan (rd_chan),
    .stat    (chk_stat)
  );

  // mod-21 correction of the reciprocal quotient; only 6 low bits matter
  always_comb begin
    q6   = mul_p[RECIP_SHIFT+5:RECIP_SHIFT];
    qm6  = 6'(12'(q6) * 12'(MOD_FACTOR));
    r21a = x_r[8:3] - qm6;
    if (r21a >= 6'(MOD_FACTOR)) begin
      r21 = r21a - 6'(MOD_FACTOR);
    end else begin
      r21 = r21a;
    end
  end

  always_comb begin
    mul_en = (state_r == S_DRAW) || (state_r == S_MULR);
    if (state_r == S_DRAW) begin
      mul_a = lcg_r;
      mul_b = GEN_MUL;
    end else begin
      mul_a = {3'b000, x_r[SEED_W-1:3]};
      mul_b = RECIP21;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    attempt_nxt = attempt_r;
    fill_nxt    = fill_r;
    out_idx_nxt = out_idx_r;
    lcg_nxt     = lcg_r;
    x_nxt       = x_r;
    r168_nxt    = r168_r;
    parity_nxt  = parity_r;

    chk_ctrl.clear  = 1'b0;
    chk_ctrl.commit = 1'b0;
    chk_ctrl.parity = parity_r;
    chk_ctrl.r168   = r168_r;

    in_ch.ready        = 1'b0;
    out_ch.valid       = 1'b0;
    out_ch.hop_channel = '0;
    out_ch.hop_index   = '0;
    out_ch.last        = 1'b0;
    out_ch.failed      = 1'b0;
    idx_ext            = 32'(out_idx_r);

    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          lcg_nxt        = in_ch.seed;
          parity_nxt     = in_ch.seed[0];
          fill_nxt       = '0;
          attempt_nxt    = '0;
          chk_ctrl.clear = 1'b1;
          state_nxt      = S_DRAW;
        end
      end
      S_DRAW: begin
        if (attempt_r >= limit_r) begin
          state_nxt = S_FAIL;
        end else begin
          attempt_nxt = attempt_r + 20'd1;
          state_nxt   = S_LCG;
        end
      end
      S_LCG: begin
        lcg_nxt   = mul_p[SEED_W-1:0] + GEN_ADD;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        x_nxt     = lcg_r >> fill_r;
        state_nxt = S_MULR;
      end
      S_MULR: begin
        state_nxt = S_RED;
      end
      S_RED: begin
        r168_nxt  = {r21[4:0], x_r[2:0]};
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_DRAW;
        if (chk_stat.ok) begin
          chk_ctrl.commit = 1'b1;
          fill_nxt        = fill_r + FW'(1);
          if (fill_r == FW'(HOP_COUNT - 1)) begin
            out_idx_nxt = '0;
            state_nxt   = S_OUT;
          end
        end
      end
      S_OUT: begin
        out_ch.valid       = 1'b1;
        out_ch.hop_channel = rd_chan;
        out_ch.hop_index   = idx_ext[INDEX_W-1:0];
        out_ch.last        = (out_idx_r == IW'(HOP_COUNT - 1));
        if (out_ch.ready) begin
          if (out_idx_r == IW'(HOP_COUNT - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + IW'(1);
          end
        end
      end
      S_FAIL: begin
        out_ch.valid  = 1'b1;
        out_ch.last   = 1'b1;
        out_ch.failed = 1'b1;
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      limit_r   <= LIMIT_RESET;
      attempt_r <= '0;
      fill_r    <= '0;
      out_idx_r <= '0;
      lcg_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      attempt_r <= attempt_nxt;
      fill_r    <= fill_nxt;
      out_idx_r <= out_idx_nxt;
      lcg_r     <= lcg_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    r168_r   <= r168_nxt;
    parity_r <= parity_nxt;
  end

  // one request in flight: never ready while a result is offered
  a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("request taken while results pending");

  a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.failed) |-> (out_ch.last && out_ch.hop_channel == '0))
    else $error("failure result malformed");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.failed) |->
      (out_ch.hop_channel != '0 && out_ch.hop_channel <= 8'd168))
    else $error("hop channel out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (fill_r < FW'(HOP_COUNT)))
    else $error("fill index past set size");

  a_attempt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LCG) |-> (attempt_r <= limit_r && attempt_r != '0))
    else $error("draw beyond attempt limit");

endmodule

`default_nettype wire

[tb/hop_set_checker.sv]
// hop_set_checker: watches the seed and hop channels of hop_set_generator,
// predicts each hop set from the seed and the attempt limit, and compares results.
// Depends on hsg_pkg and the hsg_seed_if / hsg_hop_if interfaces.
`timescale 1ns / 1ps

module hop_set_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [hsg_pkg::LIMIT_W-1:0] cfg_wr_data,
  hsg_seed_if                         in_ch,
  hsg_hop_if                          out_ch,
  output int                          fail_count,
  output int                          pending_results
);

  localparam int SET_SIZE   = hsg_pkg::HOP_COUNT_DEF;
  localparam int BAND_COUNT = hsg_pkg::NUM_BANDS_DEF;
  localparam int BAND_STEP  = 42;
  localparam int BAND_MAX   = 5;

  localparam logic [31:0] STEP_MUL  = 32'h0019660d;
  localparam logic [31:0] STEP_ADD  = 32'h3c6ef35f;
  localparam logic [31:0] CHAN_SPAN = 32'd168;

  localparam logic [hsg_pkg::LIMIT_W-1:0] DEFAULT_LIMIT = 20'd100000;

  typedef struct packed {
    logic [hsg_pkg::CHAN_W-1:0]  chan;
    logic [hsg_pkg::INDEX_W-1:0] idx;
    logic                        last;
    logic                        failed;
  } hop_entry_t;

  hop_entry_t                  expected_hops[$];
  logic [hsg_pkg::LIMIT_W-1:0] draw_limit = DEFAULT_LIMIT;
  int                          errs = 0;
  hop_entry_t                  want;

  assign fail_count = errs;

  function automatic void build_hop_set(input logic [31:0] seed);
    logic [31:0] lcg;
    logic [7:0]  chosen [SET_SIZE];
    int          band_fill [BAND_COUNT];
    int          filled;
    int          draws;
    int          cand;
    int          band;
    bit          dup;
    hop_entry_t  e;
    lcg = seed;
    filled = 0;
    draws = 0;
    foreach (band_fill[b]) band_fill[b] = 0;
    while (filled < SET_SIZE) begin
      if (draws >= int'(draw_limit)) begin
        e.chan = '0;
        e.idx = '0;
        e.last = 1'b1;
        e.failed = 1'b1;
        expected_hops.push_back(e);
        return;
      end
      draws++;
      lcg = lcg * STEP_MUL + STEP_ADD;
      cand = int'((lcg >> (filled % 32)) % CHAN_SPAN) + 1;
      if ((cand & 1) != int'(seed[0])) begin
        dup = 1'b0;
        for (int k = 0; k < filled; k++)
          if (int'(chosen[k]) == cand) dup = 1'b1;
        band = (cand - 1) / BAND_STEP;
        if (band > BAND_COUNT - 1) band = BAND_COUNT - 1;
        if (!dup && band_fill[band] < BAND_MAX) begin
          band_fill[band]++;
          chosen[filled] = 8'(cand);
          filled++;
        end
      end
    end
    for (int k = 0; k < SET_SIZE; k++) begin
      e.chan = chosen[k];
      e.idx = 4'(k);
      e.last = (k == SET_SIZE - 1);
      e.failed = 1'b0;
      expected_hops.push_back(e);
    end
  endfunction

  function automatic void check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_hops.delete();
      draw_limit = DEFAULT_LIMIT;
      pending_results <= 0;
    end else begin
      if (cfg_wr_en) draw_limit = cfg_wr_data;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hops.size() == 0) begin
          $error("unexpected hop result: channel %0d index %0d last %0d failed %0d",
                 out_ch.hop_channel, out_ch.hop_index, out_ch.last, out_ch.failed);
          errs++;
        end else begin
          want = expected_hops.pop_front();
          check_field("hop_channel", want.chan, out_ch.hop_channel);
          check_field("hop_index", want.idx, out_ch.hop_index);
          check_field("last", want.last, out_ch.last);
          check_field("failed", want.failed, out_ch.failed);
        end
      end
      if (in_ch.valid && in_ch.ready) build_hop_set(in_ch.seed);
      pending_results <= expected_hops.size();
    end
  end

endmodule

[tb/tb_hop_set_generator.sv]
// tb_hop_set_generator: drives seed requests and attempt limit writes into
// hop_set_generator with random gaps and stalls; hop_set_checker judges results.
// Depends on hsg_pkg, hsg_if, hop_set_generator and hop_set_checker.
`timescale 1ns / 1ps

module tb_hop_set_generator;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int MAX_GAP     = 17;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_wr_en = 1'b0;
  logic [hsg_pkg::LIMIT_W-1:0] cfg_wr_data = '0;
  int                          fail_count;
  int                          pending_results;
  int unsigned                 cycle_count = 0;
  bit                          no_idle = 1'b0;

  hsg_seed_if seed_bus ();
  hsg_hop_if  hop_bus ();

  always #2 clk = ~clk;

  hop_set_generator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (seed_bus),
    .out_ch      (hop_bus)
  );

  hop_set_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_ch           (seed_bus),
    .out_ch          (hop_bus),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  function automatic int pick_gap();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic push_seed(input logic [31:0] seed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      seed_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seed_bus.valid <= 1'b1;
    seed_bus.seed <= seed;
    do @(posedge clk); while (!seed_bus.ready);
  endtask

  task automatic wait_idle();
    seed_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [hsg_pkg::LIMIT_W-1:0] value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: random stall before each hop result
  initial begin
    int stall;
    hop_bus.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        hop_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hop_bus.ready <= 1'b1;
      do @(posedge clk); while (!hop_bus.valid);
    end
  end

  initial begin
    logic [31:0]                 corner_seeds [8];
    logic [hsg_pkg::LIMIT_W-1:0] phase_limits [8];
    corner_seeds = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
    phase_limits = '{20'hFFFFF, 20'd20, 20'd32, 20'd40, 20'd48, 20'd64, 20'd0,
                     20'd100000};
    phase_limits[6] = $urandom_range(65, 20'hFFFFF);
    seed_bus.valid = 1'b0;
    seed_bus.seed = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit, extreme seeds
    foreach (corner_seeds[i]) push_seed(corner_seeds[i]);

    // limit exhausted after the first draw
    write_limit(20'd1);
    push_seed(32'h0000_0000);
    push_seed(32'hFFFF_FFFF);

    // zero limit fails at once
    write_limit(20'd0);
    push_seed(32'h1234_5678);
    push_seed(32'h0000_0001);

    // just enough draws only if none were rejected
    write_limit(20'd16);
    push_seed(32'hDEAD_BEEF);
    push_seed($urandom());

    write_limit(20'hFFFFF);
    push_seed(32'hFFFF_FFFF);
    push_seed(32'h0000_0000);

    for (int p = 0; p < 8; p++) begin
      write_limit(phase_limits[p]);
      no_idle = (p == 2) || ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 51; n++) begin
        if ($urandom_range(0, 39) == 0) wait_idle();
        push_seed($urandom());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
